// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the dead-time delay line.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define DTDL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define DTDL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DTDL_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTDL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/dtdl_pkg.sv -----
// ----------------------------------------------------------------------------
// dtdl_pkg
// Shared types and constants of the dead-time delay line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtdl_pkg;

	// Ring geometry
	localparam int MAX_DEPTH = 256;
	localparam int AW        = $clog2(MAX_DEPTH);
	localparam int LW        = $clog2(MAX_DEPTH + 1);
	localparam int DW        = 32;

	// Configuration register widths and port geometry
	localparam int DELAY_W    = 16;
	localparam int BUF_LEN_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

	// Configuration reset values
	localparam logic                 ENABLE_RST = 1'b1;
	localparam logic [DELAY_W-1:0]   DELAY_RST  = 16'd0;
	localparam logic [BUF_LEN_W-1:0] LENGTH_RST = 9'd10;

	typedef struct packed {
		logic signed [DW-1:0] sample_in;
		logic                 dead_time_on;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] sample_out;
		logic                 out_valid;
		logic                 dead_time_echo;
		logic                 delay_running;
	} rsp_t;

	// Ring port controls
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} ring_cmd_t;

	// Where the result sample comes from
	typedef enum logic [1:0] {
		SRC_HOLD,
		SRC_INPUT,
		SRC_RING
	} src_t;

	typedef enum logic {
		ST_RUN,
		ST_FILL
	} fsm_t;

endpackage

`default_nettype wire

// ----- rtl/dtdl_ring.sv -----
// ----------------------------------------------------------------------------
// dtdl_ring
// Sample ring: one write port, one registered read port, per-entry written
// flags so that a read reports on rd_ok whether its entry was written since reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtdl_ring (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dtdl_pkg::ring_cmd_t       cmd,
	output logic     [dtdl_pkg::DW-1:0]    rd_data,
	output logic                           rd_ok
);

	logic [dtdl_pkg::DW-1:0] mem [dtdl_pkg::MAX_DEPTH];
	logic [dtdl_pkg::MAX_DEPTH-1:0] written_q;

	// Write and read the sample array
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rd_data <= mem[cmd.raddr];
		end
	end

	// Track entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok     <= 1'b0;
		end else begin
			if (cmd.we) begin
				written_q[cmd.waddr] <= 1'b1;
			end
			if (cmd.re) begin
				rd_ok <= written_q[cmd.raddr];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dead_time_delay_line_top.sv -----
// A result is offered in the cycle after its request is accepted.
// Throughput: one request per cycle while the delay runs or passes through, as long as each result is taken.
// A request with dead time on that finds the delay inactive starts a fill of the
// ring through its single write port; no request is taken until entries 1 .. L - 1
// hold its sample, L being buffer_length clamped to 1 .. MAX_DEPTH.
// Reset clears control state and the written flags; unwritten entries read as zero.
// ----------------------------------------------------------------------------
// dead_time_delay_line_top
// Dead-time element: ring buffer delay of a signed sample stream with
// activation fill, delay clamping and output hold while disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dead_time_delay_line_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire dtdl_pkg::req_t                       req,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output dtdl_pkg::rsp_t                            rsp,
	input  wire logic                                 cfg_we,
	input  wire logic [dtdl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dtdl_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = dtdl_pkg::AW;
	localparam int LW = dtdl_pkg::LW;
	localparam int DW = dtdl_pkg::DW;
	localparam int DLW = dtdl_pkg::DELAY_W;
	localparam logic [LW-1:0] LEN_MAX = LW'(dtdl_pkg::MAX_DEPTH);

	// Configuration registers
	logic                            enable_q;
	logic [DLW-1:0]                  delay_q;
	logic [dtdl_pkg::BUF_LEN_W-1:0]  length_q;

	// Block state
	logic [AW-1:0]   wi_q;
	logic            active_q;
	logic            echo_q;
	logic [DW-1:0]   held_q;
	dtdl_pkg::fsm_t  state_q, state_d;
	logic [LW-1:0]   fill_cnt_q;
	logic [LW-1:0]   fill_len_q;
	logic [DW-1:0]   fill_val_q;

	// Result stage
	logic               rsp_v_s1;
	dtdl_pkg::src_t     src_s1;
	logic [DW-1:0]      sample_s1;
	logic               ok_s1;
	logic               echo_s1;
	logic               run_s1;

	// Step decode
	logic               req_fire;
	logic               rsp_fire;
	logic               fill_busy;
	logic               fill_start;
	logic               step_run;
	logic [LW-1:0]      len;
	logic [LW-1:0]      wi_ext;
	logic [LW-1:0]      wi_eff;
	logic [LW-1:0]      n;
	logic               n_ok;
	logic [DLW-1:0]     dm1;
	logic [LW-1:0]      rd_idx;
	logic [LW-1:0]      wi_inc;
	logic [AW-1:0]      wi_next;
	dtdl_pkg::src_t     src_d;
	logic               ok_d;

	dtdl_pkg::ring_cmd_t ring_cmd;
	logic [DW-1:0]       ring_rd_data;
	logic                ring_rd_ok;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= dtdl_pkg::ENABLE_RST;
			delay_q  <= dtdl_pkg::DELAY_RST;
			length_q <= dtdl_pkg::LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtdl_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				dtdl_pkg::REG_DELAY:  delay_q  <= cfg_data[DLW-1:0];
				dtdl_pkg::REG_LENGTH: length_q <= cfg_data[dtdl_pkg::BUF_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length, clamped to 1 .. MAX_DEPTH
	always_comb begin
		if (length_q == '0) begin
			len = LW'(1);
		end else if (LW'(length_q) > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = LW'(length_q);
		end
	end

	// Delay tap and ring addresses
	always_comb begin
		wi_ext = LW'(wi_q);
		wi_eff = (wi_ext >= len) ? '0 : wi_ext;
		dm1    = delay_q - DLW'(1);
		if (delay_q == '0) begin
			n    = '0;
			n_ok = 1'b0;
		end else if (dm1 >= DLW'(len)) begin
			n    = len - LW'(1);
			n_ok = 1'b0;
		end else begin
			n    = dm1[LW-1:0];
			n_ok = 1'b1;
		end
		rd_idx  = (wi_eff >= n) ? (wi_eff - n) : (wi_eff + len - n);
		wi_inc  = wi_eff + LW'(1);
		wi_next = (wi_inc >= len) ? '0 : wi_inc[AW-1:0];
	end

	// Handshakes
	assign fill_busy  = (state_q == dtdl_pkg::ST_FILL);
	assign req_fire   = req_valid && req_ready;
	assign rsp_fire   = rsp_valid && rsp_ready;
	assign fill_start = req_fire && enable_q && req.dead_time_on && !active_q;
	assign step_run   = req_fire && enable_q && req.dead_time_on && active_q;

	// Result source of the accepted request
	always_comb begin
		if (!enable_q) begin
			src_d = dtdl_pkg::SRC_HOLD;
			ok_d  = 1'b0;
		end else if (!req.dead_time_on || !active_q) begin
			src_d = dtdl_pkg::SRC_INPUT;
			ok_d  = 1'b1;
		end else begin
			src_d = (n == '0) ? dtdl_pkg::SRC_INPUT : dtdl_pkg::SRC_RING;
			ok_d  = n_ok;
		end
	end

	// Fill sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtdl_pkg::ST_RUN: begin
				if (fill_start && len != LW'(1)) begin
					state_d = dtdl_pkg::ST_FILL;
				end
			end
			dtdl_pkg::ST_FILL: begin
				if (fill_cnt_q == fill_len_q - LW'(1)) begin
					state_d = dtdl_pkg::ST_RUN;
				end
			end
			default: state_d = dtdl_pkg::ST_RUN;
		endcase
	end

	// Fill sequencer: ready and ring port drive
	always_comb begin
		req_ready = 1'b0;
		ring_cmd  = '0;
		unique case (state_q)
			dtdl_pkg::ST_RUN: begin
				req_ready = !rsp_v_s1 || rsp_ready;
				if (fill_start) begin
					ring_cmd.we    = 1'b1;
					ring_cmd.waddr = '0;
					ring_cmd.wdata = req.sample_in;
				end else if (step_run) begin
					ring_cmd.we    = 1'b1;
					ring_cmd.waddr = wi_eff[AW-1:0];
					ring_cmd.wdata = req.sample_in;
					ring_cmd.re    = (n != '0);
					ring_cmd.raddr = rd_idx[AW-1:0];
				end
			end
			dtdl_pkg::ST_FILL: begin
				ring_cmd.we    = 1'b1;
				ring_cmd.waddr = fill_cnt_q[AW-1:0];
				ring_cmd.wdata = fill_val_q;
			end
			default: ;
		endcase
	end

	// Advance block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtdl_pkg::ST_RUN;
			wi_q       <= '0;
			active_q   <= 1'b0;
			echo_q     <= 1'b0;
			held_q     <= '0;
			fill_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (req_fire && enable_q) begin
				echo_q <= req.dead_time_on;
				if (!req.dead_time_on) begin
					active_q <= 1'b0;
				end else if (!active_q) begin
					active_q <= 1'b1;
				end else begin
					wi_q <= wi_next;
				end
			end
			if (fill_start) begin
				fill_cnt_q <= LW'(1);
			end else if (fill_busy) begin
				fill_cnt_q <= fill_cnt_q + LW'(1);
			end
			if (rsp_fire) begin
				held_q <= rsp.sample_out;
			end
		end
	end

	// Capture fill value and length
	always_ff @(posedge clk) begin
		if (fill_start) begin
			fill_val_q <= req.sample_in;
			fill_len_q <= len;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_s1 <= 1'b0;
		end else if (req_fire) begin
			rsp_v_s1 <= 1'b1;
		end else if (rsp_fire) begin
			rsp_v_s1 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			src_s1    <= src_d;
			sample_s1 <= req.sample_in;
			ok_s1     <= ok_d;
			echo_s1   <= enable_q ? req.dead_time_on : echo_q;
			if (!enable_q) begin
				run_s1 <= active_q;
			end else begin
				run_s1 <= req.dead_time_on;
			end
		end
	end

	dtdl_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ring_cmd),
		.rd_data (ring_rd_data),
		.rd_ok   (ring_rd_ok)
	);

	// Drive the result
	assign rsp_valid = rsp_v_s1;

	always_comb begin
		case (src_s1)
			dtdl_pkg::SRC_HOLD:  rsp.sample_out = held_q;
			dtdl_pkg::SRC_INPUT: rsp.sample_out = sample_s1;
			dtdl_pkg::SRC_RING:  rsp.sample_out = ring_rd_ok ? ring_rd_data : '0;
			default:             rsp.sample_out = held_q;
		endcase
		rsp.out_valid      = ok_s1;
		rsp.dead_time_echo = echo_s1;
		rsp.delay_running  = run_s1;
	end

	// Checks
	`DTDL_ASSERT_NEVER(a_no_req_in_fill, clk, arst_n, fill_busy && req_fire,
		"request accepted during ring fill")
	`DTDL_ASSERT(a_rw_apart, clk, arst_n,
		(ring_cmd.re && ring_cmd.we) |-> (ring_cmd.raddr != ring_cmd.waddr),
		"ring read and write hit the same entry")
	`DTDL_ASSERT(a_slot_free, clk, arst_n, (req_fire && rsp_v_s1) |-> rsp_ready,
		"request accepted over an untaken result")

endmodule

`default_nettype wire
